### src/ffpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ffpa_pkg;

    // pool geometry; POOL_UNITS must be a multiple of SCAN_CHUNK
    localparam int POOL_UNITS  = 128;
    localparam int UNIT_W      = $clog2(POOL_UNITS);
    localparam int RUN_W       = $clog2(POOL_UNITS + 1);
    localparam int SPAN_W      = UNIT_W + 2;
    localparam int LEN_W       = 8;
    localparam int SCAN_CHUNK  = 8;
    localparam int NUM_CHUNKS  = POOL_UNITS / SCAN_CHUNK;
    localparam int CHUNK_IDX_W = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;

    // operation codes
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // status codes
    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] request_size;
        logic [6:0] release_start;
    } in_t;

    typedef struct packed {
        logic       status;
        logic [6:0] granted_start;
    } out_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_REL,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic mark;
        logic free;
        logic fail;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic size_bad;
        logic found;
        logic last_chunk;
        logic rel_ok;
    } dp_sts_t;

endpackage

`default_nettype wire

### src/ffpa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ffpa_ctrl
    import ffpa_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire logic    in_operation,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // state and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_operation == OP_RELEASE)
                        state_next = S_REL;
                    else
                        state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.size_bad)
                begin
                    cmd.fail   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.scan = 1'b1;
                    if (sts.found)
                        state_next = S_MARK;
                    else if (sts.last_chunk)
                    begin
                        cmd.fail   = 1'b1;
                        state_next = S_DONE;
                    end
                end
            end
            S_MARK:
            begin
                cmd.mark   = 1'b1;
                state_next = S_DONE;
            end
            S_REL:
            begin
                if (sts.rel_ok)
                    cmd.free = 1'b1;
                else
                    cmd.fail = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid holds until taken
    always_comb
    begin
        out_valid_next = cmd.out_load | (out_valid_reg & ~out_ready);
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### src/ffpa_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ffpa_dp
    import ffpa_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire in_t     in_item,
    input  wire dp_cmd_t cmd,
    output dp_sts_t      sts,
    output out_t         out_item
);

    in_t                    item_reg;
    logic [POOL_UNITS-1:0]  busy_reg;
    logic [POOL_UNITS-1:0]  busy_next;
    logic [CHUNK_IDX_W-1:0] chunk_reg;
    logic [RUN_W-1:0]       run_reg;
    logic [UNIT_W-1:0]      start_reg;
    logic                   res_err_reg;
    logic [6:0]             res_start_reg;
    out_t                   out_item_reg;

    // run length table with per-entry valid bits
    logic [LEN_W-1:0]       len_mem [POOL_UNITS];
    logic [POOL_UNITS-1:0]  len_vld_reg;
    logic [LEN_W-1:0]       rd_len_reg;
    logic                   rd_vld_reg;

    logic [SCAN_CHUNK-1:0]  chunk_bits;
    logic [RUN_W-1:0]       run_v;
    logic [RUN_W-1:0]       size_run;
    logic                   found_v;
    logic [UNIT_W-1:0]      start_v;
    logic [UNIT_W-1:0]      rel_idx;
    logic [UNIT_W-1:0]      span_lo;
    logic [SPAN_W-1:0]      span_hi;
    logic [POOL_UNITS-1:0]  span_mask;

    assign rel_idx  = UNIT_W'(item_reg.release_start);
    assign size_run = RUN_W'(item_reg.request_size);

    // status toward the controller
    always_comb
    begin
        sts.size_bad   = (item_reg.request_size == '0) ||
                         (int'(item_reg.request_size) > POOL_UNITS);
        sts.found      = found_v;
        sts.last_chunk = (int'(chunk_reg) == NUM_CHUNKS - 1);
        sts.rel_ok     = (int'(item_reg.release_start) < POOL_UNITS) &&
                         rd_vld_reg && (rd_len_reg != '0);
    end

    // first-fit scan over one group of units
    always_comb
    begin
        chunk_bits = busy_reg[int'(chunk_reg) * SCAN_CHUNK +: SCAN_CHUNK];
        run_v      = run_reg;
        found_v    = 1'b0;
        start_v    = '0;
        for (int j = 0; j < SCAN_CHUNK; j++)
        begin
            if (chunk_bits[j])
                run_v = '0;
            else
            begin
                run_v = run_v + RUN_W'(1);
                if (!found_v && run_v == size_run)
                begin
                    found_v = 1'b1;
                    start_v = UNIT_W'(SPAN_W'(int'(chunk_reg) * SCAN_CHUNK + j + 1)
                                      - SPAN_W'(item_reg.request_size));
                end
            end
        end
    end

    // span of units touched by a grant or a release
    always_comb
    begin
        if (cmd.mark)
        begin
            span_lo = start_reg;
            span_hi = SPAN_W'(start_reg) + SPAN_W'(item_reg.request_size);
        end
        else
        begin
            span_lo = rel_idx;
            span_hi = SPAN_W'(rel_idx) + SPAN_W'(rd_len_reg);
        end
        for (int i = 0; i < POOL_UNITS; i++)
            span_mask[i] = (SPAN_W'(i) >= SPAN_W'(span_lo)) && (SPAN_W'(i) < span_hi);
    end

    // bitmap update
    always_comb
    begin
        busy_next = busy_reg;
        if (cmd.mark)
            busy_next = busy_reg | span_mask;
        else if (cmd.free)
            busy_next = busy_reg & ~span_mask;
    end

    // control registers: bitmap, valid bits, scan position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= '0;
            len_vld_reg <= '0;
            chunk_reg   <= '0;
            run_reg     <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (cmd.mark)
                len_vld_reg[start_reg] <= 1'b1;
            else if (cmd.free)
                len_vld_reg[rel_idx] <= 1'b0;
            if (cmd.load)
            begin
                chunk_reg <= '0;
                run_reg   <= '0;
            end
            else if (cmd.scan)
            begin
                chunk_reg <= chunk_reg + CHUNK_IDX_W'(1);
                run_reg   <= run_v;
            end
        end
    end

    // length table write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.mark)
            len_mem[start_reg] <= item_reg.request_size;
        if (cmd.load)
        begin
            rd_len_reg <= len_mem[UNIT_W'(in_item.release_start)];
            rd_vld_reg <= len_vld_reg[UNIT_W'(in_item.release_start)];
        end
    end

    // item, result and output payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= in_item;
        if (cmd.scan && found_v)
            start_reg <= start_v;
        if (cmd.mark)
        begin
            res_err_reg   <= ST_OK;
            res_start_reg <= 7'(start_reg);
        end
        else if (cmd.free)
        begin
            res_err_reg   <= ST_OK;
            res_start_reg <= '0;
        end
        else if (cmd.fail)
        begin
            res_err_reg   <= ST_ERR;
            res_start_reg <= '0;
        end
        if (cmd.out_load)
        begin
            out_item_reg.status        <= res_err_reg;
            out_item_reg.granted_start <= res_start_reg;
        end
    end

    assign out_item = out_item_reg;

endmodule

`default_nettype wire

### src/first_fit_pool_allocator.sv
// First-fit pool allocator over 128 equal units.
// Input channel (in_valid/in_ready/in_item): operation 0 requests a run of
// request_size contiguous units, operation 1 releases the run that starts at
// release_start. Output channel (out_valid/out_ready/out_item): one item per
// input item with status (0 ok, 1 error) and granted_start (0 unless a
// request succeeded).
// After acceptance, a release passes through S_REL, and a request through
// S_SCAN, where the first-fit scan walks the 8-unit groups in order (1 to 16)
// and fails without scanning on a bad size, or after the last group if no run
// fits; a request that fits then passes through S_MARK. Every item ends in
// S_DONE, from which out_valid is registered. The scan unit checks 8 units of
// the occupancy bitmap per cycle.
// One item is in flight at a time; in_ready is high whenever the block is
// idle, even while the previous result still sits in the output register.
// If the receiver stalls, a finished result waits until the output register
// frees up, and no further item is taken meanwhile.
// Reset (rst_n low, asynchronous) frees all units and marks every length
// table entry empty at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_pool_allocator
    import ffpa_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire in_t  in_item,
    output logic      out_valid,
    input  wire logic out_ready,
    output out_t      out_item
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencing
    ffpa_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_operation (in_item.operation),
        .in_ready     (in_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    // bitmap, scan unit and length table
    ffpa_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .cmd      (cmd),
        .sts      (sts),
        .out_item (out_item)
    );

endmodule

`default_nettype wire

### src/ffpa_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ffpa_checker
    import ffpa_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire in_t  in_item,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire out_t out_item
);

    // a stalled result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("output item changed while stalled");

    // a waiting input item stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_item))
        else $error("input item changed while waiting");

    // an error never carries a start unit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.status == ST_ERR) |-> out_item.granted_start == '0)
        else $error("error item with nonzero start");

    // only one item in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while busy");

    // nothing is shown right after reset
    assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid right after reset");

endmodule

bind first_fit_pool_allocator ffpa_checker u_ffpa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

`default_nettype wire
